/* hw/rtl/subevent_block_deframer_unit_macros.svh */
// Assertion macros for the subevent block deframer.
// Expect i_clk and i_rst_n in the scope of every use.
`ifndef SUBEVENT_BLOCK_DEFRAMER_UNIT_MACROS_SVH
`define SUBEVENT_BLOCK_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define SBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sbd_pkg.sv */
// Types, codes and step helpers of the subevent block deframer.
// No dependencies; used by the result channel interface, the step logic and the top level.
package sbd_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'habad1dea;
    localparam logic [15:0] DUMMY_ID   = 16'h5555;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic [2:0] t_class;
    localparam t_class CLS_BLOCK_HDR = 3'd0;
    localparam t_class CLS_HUB_HDR   = 3'd1;
    localparam t_class CLS_TRIGGER   = 3'd2;
    localparam t_class CLS_SKIPPED   = 3'd3;
    localparam t_class CLS_SYNC      = 3'd4;
    localparam t_class CLS_TDC       = 3'd5;
    localparam t_class CLS_OTHER     = 3'd6;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_MAGIC = 2'd0;
    localparam t_kind KIND_TDC   = 2'd1;
    localparam t_kind KIND_DUMMY = 2'd2;
    localparam t_kind KIND_NONE  = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CTS_ID      = 3'd0;
    localparam t_cfg_idx CFG_HUB_ID_A    = 3'd1;
    localparam t_cfg_idx CFG_HUB_ID_B    = 3'd2;
    localparam t_cfg_idx CFG_TDC_ID_LOW  = 3'd3;
    localparam t_cfg_idx CFG_TDC_ID_HIGH = 3'd4;
    localparam t_cfg_idx CFG_CTS_TDC_EN  = 3'd5;

    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_TRIG = 3'd1,
        PH_SKIP = 3'd2,
        PH_MOD  = 3'd3,
        PH_TAIL = 3'd4,
        PH_DATA = 3'd5
    } t_phase;

    typedef struct packed {
        logic [15:0] cts_id;
        logic [15:0] hub_id_a;
        logic [15:0] hub_id_b;
        logic [15:0] tdc_id_low;
        logic [15:0] tdc_id_high;
        logic        cts_tdc_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cts_id:         16'h8000,
        hub_id_a:       16'h0000,
        hub_id_b:       16'h0000,
        tdc_id_low:     16'h0001,
        tdc_id_high:    16'h0000,
        cts_tdc_enable: 1'b0
    };

    typedef struct packed {
        t_phase      phase;
        logic [15:0] block_remaining;
        logic [15:0] hub_budget;
        logic [6:0]  info_skip_left;
        t_kind       module_kind;
        logic [2:0]  module_word_index;
        logic [15:0] current_block_id;
        logic        found;
        logic [31:0] sync_number;
        logic [31:0] sync_state;
        logic [47:0] sync_time;
        logic [31:0] period;
        logic [31:0] length;
        logic [15:0] trigger;
        logic        overrun;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:             PH_HDR,
        block_remaining:   16'd0,
        hub_budget:        16'd0,
        info_skip_left:    7'd0,
        module_kind:       KIND_MAGIC,
        module_word_index: 3'd0,
        current_block_id:  16'd0,
        found:             1'b0,
        sync_number:       32'd0,
        sync_state:        32'd0,
        sync_time:         48'd0,
        period:            32'd0,
        length:            32'd0,
        trigger:           16'd0,
        overrun:           1'b0
    };

    typedef struct packed {
        t_class      word_class;
        logic [15:0] dest_id;
        logic [31:0] payload;
        logic        end_of_subevent;
        logic        sync_found;
        logic [31:0] sync_number;
        logic [31:0] sync_state_word;
        logic [15:0] trigger_code;
        logic [47:0] sync_time;
        logic [31:0] sync_pulse_period;
        logic [31:0] sync_pulse_length;
        logic        overrun_flag;
    } t_result;

    function automatic t_state consume(t_state s);
        t_state r;
        r = s;
        if (r.block_remaining != 16'd0) begin
            r.block_remaining = r.block_remaining - 16'd1;
        end else begin
            r.overrun = 1'b1;
        end
        return r;
    endfunction

    function automatic t_state enter_tail(t_state s);
        t_state r;
        r = s;
        r.phase = (r.block_remaining != 16'd0) ? PH_TAIL : PH_HDR;
        return r;
    endfunction

    function automatic t_state enter_module(t_state s);
        t_state r;
        r = s;
        r.module_word_index = 3'd0;
        if (r.module_kind == KIND_MAGIC) begin
            r.found       = 1'b0;
            r.sync_number = '0;
            r.sync_state  = '0;
            r.sync_time   = '0;
            r.period      = '0;
            r.length      = '0;
        end
        if (r.module_kind == KIND_NONE) begin
            r = enter_tail(r);
        end else begin
            r.phase = PH_MOD;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/sbd_in_if.sv */
// Input word channel of the subevent block deframer.
// Depends on nothing; carries valid, ready, one payload word and a last flag.
interface sbd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

/* hw/rtl/sbd_out_if.sv */
// Result channel of the subevent block deframer.
// Depends on sbd_pkg for the word class type.
interface sbd_out_if;
    logic                valid;
    logic                ready;
    sbd_pkg::t_class     word_class;
    logic [15:0]         dest_id;
    logic [31:0]         payload;
    logic                end_of_subevent;
    logic                sync_found;
    logic [31:0]         sync_number;
    logic [31:0]         sync_state_word;
    logic [15:0]         trigger_code;
    logic [47:0]         sync_time;
    logic [31:0]         sync_pulse_period;
    logic [31:0]         sync_pulse_length;
    logic                overrun_flag;

    modport source (output valid, output word_class, output dest_id, output payload,
                    output end_of_subevent, output sync_found, output sync_number,
                    output sync_state_word, output trigger_code, output sync_time,
                    output sync_pulse_period, output sync_pulse_length,
                    output overrun_flag, input ready);
    modport sink   (input valid, input word_class, input dest_id, input payload,
                    input end_of_subevent, input sync_found, input sync_number,
                    input sync_state_word, input trigger_code, input sync_time,
                    input sync_pulse_period, input sync_pulse_length,
                    input overrun_flag, output ready);
endinterface

/* hw/rtl/sbd_step.sv */
// Per-word decode of the subevent block deframer: next state and tagged result.
// Depends on sbd_pkg for state, configuration and result types.
module sbd_step (
    input  sbd_pkg::t_cfg    i_cfg,
    input  sbd_pkg::t_state  i_state,
    input  logic [31:0]      i_word,
    input  logic             i_last,
    output sbd_pkg::t_state  o_state,
    output sbd_pkg::t_result o_res
);
    import sbd_pkg::*;

    t_state      s;
    t_state      n;
    t_class      cls;
    logic [15:0] dest;
    logic [15:0] len;
    logic [15:0] id;
    logic        is_hub;
    logic [2:0]  idx;
    logic        done;

    always_comb begin
        s    = i_state;
        cls  = CLS_SKIPPED;
        dest = s.current_block_id;
        len  = i_word[31:16];
        id   = i_word[15:0];
        idx  = s.module_word_index;
        done = 1'b0;
        is_hub = ((i_cfg.hub_id_a != 16'd0) && (id == i_cfg.hub_id_a)) ||
                 ((i_cfg.hub_id_b != 16'd0) && (id == i_cfg.hub_id_b));

        // drop out of the magic-word module when its first word is no magic word
        if ((s.phase == PH_MOD) && (s.module_kind == KIND_MAGIC) &&
            (s.module_word_index == 3'd0) && (i_word != MAGIC_WORD)) begin
            s = enter_tail(s);
        end
        n = s;

        case (s.phase)
            PH_HDR: begin
                dest = id;
                if (is_hub) begin
                    cls = CLS_HUB_HDR;
                    n.hub_budget = (s.hub_budget == 16'd0) ? len : s.hub_budget - 16'd1;
                end else begin
                    cls = CLS_BLOCK_HDR;
                    if (s.hub_budget != 16'd0) begin
                        if (len >= s.hub_budget) begin
                            n.overrun = 1'b1;
                            len = s.hub_budget - 16'd1;
                        end
                        n.hub_budget = s.hub_budget - (len + 16'd1);
                    end
                    n.current_block_id = id;
                    n.block_remaining  = len;
                    if (id == i_cfg.cts_id) begin
                        n.phase = PH_TRIG;
                    end else begin
                        if ((id >= i_cfg.tdc_id_low) && (id <= i_cfg.tdc_id_high)) begin
                            n.module_kind = KIND_TDC;
                        end else if (id == DUMMY_ID) begin
                            n.module_kind = KIND_DUMMY;
                        end else begin
                            n.module_kind = KIND_MAGIC;
                        end
                        n.phase = (len != 16'd0) ? PH_DATA : PH_HDR;
                    end
                end
            end
            PH_TRIG: begin
                cls = CLS_TRIGGER;
                n.trigger     = i_word[15:0];
                n.module_kind = i_word[29:28];
                n.info_skip_left = 7'({i_word[19:16], 1'b0}) + 7'({i_word[23:20], 1'b0})
                                 + 7'({i_word[25], 1'b0}) + 7'({i_word[26], 1'b0})
                                 + 7'(i_word[26]) + 7'(i_word[27]);
                n = consume(n);
                if (n.info_skip_left != 7'd0) begin
                    n.phase = PH_SKIP;
                end else begin
                    n = enter_module(n);
                end
            end
            PH_SKIP: begin
                cls = CLS_SKIPPED;
                n = consume(n);
                if (n.info_skip_left != 7'd0) begin
                    n.info_skip_left = n.info_skip_left - 7'd1;
                end
                if (n.info_skip_left == 7'd0) begin
                    n = enter_module(n);
                end
            end
            PH_MOD: begin
                cls = CLS_SYNC;
                n = consume(n);
                case (s.module_kind)
                    KIND_MAGIC: begin
                        case (idx)
                            3'd0: n.found = 1'b1;
                            3'd1: begin
                                n.sync_number = {16'd0, i_word[31:16]};
                                n.sync_state  = '0;
                                n.sync_time   = {i_word[15:0], s.sync_time[31:0]};
                            end
                            3'd2: n.sync_time = {s.sync_time[47:32], i_word};
                            3'd3: n.period = i_word;
                            default: begin
                                n.length = i_word;
                                done = 1'b1;
                            end
                        endcase
                    end
                    KIND_TDC: begin
                        n.sync_number = {8'd0, i_word[23:0]};
                        n.sync_state  = {24'd0, i_word[31:24]};
                        n.found = 1'b1;
                        done = 1'b1;
                    end
                    default: begin
                        if (idx == 3'd0) begin
                            n.sync_number = i_word;
                            n.found = 1'b1;
                        end else if (idx == 3'd1) begin
                            n.sync_state = i_word;
                        end else begin
                            cls = CLS_SKIPPED;
                            done = (idx >= 3'd3);
                        end
                    end
                endcase
                if (done) begin
                    n.module_word_index = 3'd0;
                    n = enter_tail(n);
                end else begin
                    n.module_word_index = idx + 3'd1;
                end
            end
            PH_TAIL: begin
                cls = i_cfg.cts_tdc_enable ? CLS_TDC : CLS_SKIPPED;
                if (n.block_remaining != 16'd0) begin
                    n.block_remaining = n.block_remaining - 16'd1;
                end
                if (n.block_remaining == 16'd0) begin
                    n.phase = PH_HDR;
                end
            end
            default: begin
                case (s.module_kind)
                    KIND_TDC:   cls = CLS_TDC;
                    KIND_DUMMY: cls = CLS_OTHER;
                    default:    cls = CLS_SKIPPED;
                endcase
                if (n.block_remaining != 16'd0) begin
                    n.block_remaining = n.block_remaining - 16'd1;
                end
                if (n.block_remaining == 16'd0) begin
                    n.phase = PH_HDR;
                end
            end
        endcase

        o_res.word_class        = cls;
        o_res.dest_id           = dest;
        o_res.payload           = i_word;
        o_res.end_of_subevent   = i_last;
        o_res.sync_found        = n.found;
        o_res.sync_number       = n.sync_number;
        o_res.sync_state_word   = n.sync_state;
        o_res.trigger_code      = n.trigger;
        o_res.sync_time         = n.sync_time;
        o_res.sync_pulse_period = n.period;
        o_res.sync_pulse_length = n.length;
        o_res.overrun_flag      = n.overrun;

        // close the subevent, keep the held sync values
        o_state = n;
        if (i_last) begin
            o_state.phase             = PH_HDR;
            o_state.block_remaining   = 16'd0;
            o_state.hub_budget        = 16'd0;
            o_state.info_skip_left    = 7'd0;
            o_state.module_kind       = KIND_MAGIC;
            o_state.module_word_index = 3'd0;
            o_state.current_block_id  = 16'd0;
            o_state.found             = 1'b0;
            o_state.overrun           = 1'b0;
            o_state.trigger           = 16'd0;
        end
    end

endmodule

/* hw/rtl/subevent_block_deframer_unit.sv */
// Path: an accepted word is held in the input register, then in the result register.
// Throughput: one word per cycle unless the output stalls; decode between the input and
// result registers is combinational, and the result register frees while it is taken.
// Reset (synchronous, active low): configuration, state and valid registers return to
// their defaults, the decoder expects a block header and all held sync values are cleared.
`include "subevent_block_deframer_unit_macros.svh"

module subevent_block_deframer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  sbd_pkg::t_cfg_idx           i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbd_in_if.sink                      i_in,
    sbd_out_if.source                   o_out
);
    import sbd_pkg::*;

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     r_res;
    t_result     n_res;
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_last;
    logic        r_out_valid;
    logic        adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CTS_ID:      r_cfg.cts_id         <= i_cfg_data;
                CFG_HUB_ID_A:    r_cfg.hub_id_a       <= i_cfg_data;
                CFG_HUB_ID_B:    r_cfg.hub_id_b       <= i_cfg_data;
                CFG_TDC_ID_LOW:  r_cfg.tdc_id_low     <= i_cfg_data;
                CFG_TDC_ID_HIGH: r_cfg.tdc_id_high    <= i_cfg_data;
                CFG_CTS_TDC_EN:  r_cfg.cts_tdc_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.word;
            r_in_last <= i_in.last;
        end
    end

    sbd_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_word  (r_in_word),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.word_class        = r_res.word_class;
    assign o_out.dest_id           = r_res.dest_id;
    assign o_out.payload           = r_res.payload;
    assign o_out.end_of_subevent   = r_res.end_of_subevent;
    assign o_out.sync_found        = r_res.sync_found;
    assign o_out.sync_number       = r_res.sync_number;
    assign o_out.sync_state_word   = r_res.sync_state_word;
    assign o_out.trigger_code      = r_res.trigger_code;
    assign o_out.sync_time         = r_res.sync_time;
    assign o_out.sync_pulse_period = r_res.sync_pulse_period;
    assign o_out.sync_pulse_length = r_res.sync_pulse_length;
    assign o_out.overrun_flag      = r_res.overrun_flag;

    `SBD_ASSERT_NEXT(a_adv_fills_out, adv, r_out_valid, "decoded word did not reach the result register")
    `SBD_ASSERT_NEXT(a_in_held, r_in_valid && !adv, r_in_valid && $stable(r_in_word), "stalled input word was lost")
    `SBD_ASSERT_NEXT(a_last_clears, adv && r_in_last, (r_state.phase == PH_HDR) && (r_state.hub_budget == 16'd0) && !r_state.found && !r_state.overrun, "subevent end did not clear the state")
    `SBD_ASSERT_NOW(a_skip_phase, r_state.info_skip_left != 7'd0, r_state.phase == PH_SKIP, "info skip count left outside the skip phase")

endmodule
